// ===== sv/stc_pkg.sv =====
// Shared types, codes and constants for the servo throttle calibrator.
// No dependencies; compiled first.
package stc_pkg;

    localparam int DATA_W = 16;
    localparam int DIVIDEND_W = 30;
    localparam int DIV_STEPS = DIVIDEND_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] DEFAULT_IDLE_US = 16'd1000;
    localparam logic [DATA_W-1:0] DEFAULT_FULL_US = 16'd2000;
    localparam logic [DATA_W-1:0] SERVO_MIN_RST = 16'd500;
    localparam logic [DATA_W-1:0] SERVO_MAX_RST = 16'd2500;
    localparam logic [DATA_W-1:0] MIN_SPAN_RST = 16'd100;

    localparam logic [13:0] PCT_FULL_SCALE = 14'd10000;
    localparam logic [6:0] PCT_QUERY_MAX = 7'd100;

    // Command codes
    localparam logic [3:0] FN_SET_PCT = 4'd0;
    localparam logic [3:0] FN_SET_WIDTH = 4'd1;
    localparam logic [3:0] FN_GO_IDLE = 4'd2;
    localparam logic [3:0] FN_BEGIN_CAL = 4'd3;
    localparam logic [3:0] FN_JOG_IDLE = 4'd4;
    localparam logic [3:0] FN_JOG_FULL = 4'd5;
    localparam logic [3:0] FN_SAVE = 4'd6;
    localparam logic [3:0] FN_CANCEL = 4'd7;
    localparam logic [3:0] FN_QUERY_PCT = 4'd8;

    // Status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_ENGINE = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_SPAN = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_SERVO_MIN = 2'd0;
    localparam logic [1:0] REG_SERVO_MAX = 2'd1;
    localparam logic [1:0] REG_MIN_SPAN = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DATA_W-1:0]     divisor;
    } stc_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } stc_div_rsp_t;

    // Raise to min first, then lower to max (max wins if the range is inverted)
    function automatic logic [DATA_W-1:0] clamp_servo(
        input logic [DATA_W-1:0] w,
        input logic [DATA_W-1:0] lo,
        input logic [DATA_W-1:0] hi
    );
        logic [DATA_W-1:0] v;
        begin
            v = (w < lo) ? lo : w;
            clamp_servo = (v > hi) ? hi : v;
        end
    endfunction

endpackage

// ===== sv/stc_if.sv =====
// Command and response channel interfaces for the servo throttle calibrator.
// Depends on nothing; valid/ready handshake with source and sink modports.
interface stc_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic [15:0]        width_us;
    logic signed [15:0] pct_hundredths;
    logic               engine_running;

    modport source (output valid, func, width_us, pct_hundredths, engine_running,
                    input ready);
    modport sink (input valid, func, width_us, pct_hundredths, engine_running,
                  output ready);
endinterface

interface stc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] servo_width;
    logic        servo_drive;
    logic [2:0]  status;
    logic [6:0]  percent_out;
    logic        in_calibration;

    modport source (output valid, servo_width, servo_drive, status, percent_out,
                    in_calibration, input ready);
    modport sink (input valid, servo_width, servo_drive, status, percent_out,
                  in_calibration, output ready);
endinterface

// ===== sv/stc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on stc_pkg.
module stc_divider
    import stc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  stc_div_req_t req,
    output stc_div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]     den_reg, den_next;
    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/servo_throttle_calibrator_unit.sv =====
// Servo throttle calibrator top level: command decode, endpoint state, sequencer.
// Depends on stc_pkg, stc_if.sv and stc_divider.
//
// Usage
//   cmd (sink): one command per transfer; rsp (source): exactly one response
//   per command, in order. cfg_we/cfg_index/cfg_data write the servo range and
//   minimum span registers; write them only while no command is in flight.
//   Commands are taken one at a time: cmd.ready is high only while the
//   sequencer is idle.
//   Plain commands go from the transfer through the done state to the response.
//   Set percent outside calibration and percent query on a non-degenerate
//   window also pass through the multiply state and the shared 30-step
//   restoring divider before the done state.
//   The response sits in an output register, so a new command is taken while
//   the previous response still waits; a command that finishes while the
//   register is full holds until rsp.ready frees it.
//   Reset: window 1000..2000 us (active and pending), normal mode, servo
//   range 500..2500 us, minimum span 100 us, no response pending.
module servo_throttle_calibrator_unit
    import stc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    stc_cmd_if.sink          cmd,
    stc_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DATA_W-1:0] smin_reg, smax_reg, span_min_reg;
    logic [DATA_W-1:0] ai_reg, ai_next, af_reg, af_next;
    logic [DATA_W-1:0] pi_reg, pi_next, pf_reg, pf_next;
    logic              cal_reg, cal_next;

    logic [DATA_W-1:0] mul_a_reg, mul_a_next;
    logic [13:0]       mul_b_reg, mul_b_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              query_reg, query_next;

    logic [DATA_W-1:0] res_width_reg, res_width_next;
    logic              res_drive_reg, res_drive_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [6:0]        res_pct_reg, res_pct_next;
    logic              res_cal_reg, res_cal_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_load;
    logic [DATA_W-1:0] rsp_width_reg;
    logic              rsp_drive_reg;
    logic [2:0]        rsp_status_reg;
    logic [6:0]        rsp_pct_reg;
    logic              rsp_cal_reg;

    logic              accept;
    logic [13:0]       pct_clamped;
    logic [DATA_W:0]   win_span, win_mag, q_diff, q_mag, save_span;
    logic [DATA_W-1:0] jog_w;

    stc_div_req_t      div_req;
    stc_div_rsp_t      div_rsp;

    stc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && (state_reg == S_IDLE);

    always_comb
    begin
        if (cmd.pct_hundredths < 0)
            pct_clamped = '0;
        else if (cmd.pct_hundredths > $signed({2'b00, PCT_FULL_SCALE}))
            pct_clamped = PCT_FULL_SCALE;
        else
            pct_clamped = cmd.pct_hundredths[13:0];
        win_span  = {1'b0, af_reg} - {1'b0, ai_reg};
        win_mag   = win_span[DATA_W] ? (~win_span + 1'b1) : win_span;
        q_diff    = {1'b0, cmd.width_us} - {1'b0, ai_reg};
        q_mag     = q_diff[DATA_W] ? (~q_diff + 1'b1) : q_diff;
        save_span = {1'b0, pf_reg} - {1'b0, pi_reg};
        jog_w     = clamp_servo(cmd.width_us, smin_reg, smax_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        ai_next         = ai_reg;
        af_next         = af_reg;
        pi_next         = pi_reg;
        pf_next         = pf_reg;
        cal_next        = cal_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        query_next      = query_reg;
        res_width_next  = res_width_reg;
        res_drive_next  = res_drive_reg;
        res_status_next = res_status_reg;
        res_pct_next    = res_pct_reg;
        res_cal_next    = res_cal_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {{(DIVIDEND_W-DATA_W){1'b0}}, mul_a_reg}
                         * {{(DIVIDEND_W-14){1'b0}}, mul_b_reg};
        div_req.divisor  = den_reg;
        rsp_load       = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_width_next  = '0;
                    res_drive_next  = 1'b0;
                    res_status_next = ST_OK;
                    res_pct_next    = '0;
                    state_next      = S_DONE;
                    case (cmd.func)
                        FN_SET_PCT:
                        begin
                            if (cal_reg)
                                res_status_next = ST_IGNORED;
                            else
                            begin
                                mul_a_next = win_mag[DATA_W-1:0];
                                mul_b_next = pct_clamped;
                                den_next   = {2'b00, PCT_FULL_SCALE};
                                neg_next   = win_span[DATA_W];
                                query_next = 1'b0;
                                state_next = S_MUL;
                            end
                        end
                        FN_SET_WIDTH:
                        begin
                            if (cal_reg)
                                res_status_next = ST_IGNORED;
                            else
                            begin
                                res_width_next = jog_w;
                                res_drive_next = 1'b1;
                            end
                        end
                        FN_GO_IDLE:
                        begin
                            if (cal_reg)
                                res_status_next = ST_IGNORED;
                            else
                            begin
                                res_width_next = ai_reg;
                                res_drive_next = 1'b1;
                            end
                        end
                        FN_BEGIN_CAL:
                        begin
                            if (cmd.engine_running)
                                res_status_next = ST_ENGINE;
                            else
                            begin
                                pi_next  = ai_reg;
                                pf_next  = af_reg;
                                cal_next = 1'b1;
                            end
                        end
                        FN_JOG_IDLE:
                        begin
                            if (!cal_reg)
                                res_status_next = ST_IGNORED;
                            else
                            begin
                                pi_next        = jog_w;
                                res_width_next = jog_w;
                                res_drive_next = 1'b1;
                            end
                        end
                        FN_JOG_FULL:
                        begin
                            if (!cal_reg)
                                res_status_next = ST_IGNORED;
                            else
                            begin
                                pf_next        = jog_w;
                                res_width_next = jog_w;
                                res_drive_next = 1'b1;
                            end
                        end
                        FN_SAVE:
                        begin
                            if (!cal_reg)
                                res_status_next = ST_IGNORED;
                            else if (pi_reg < smin_reg || pf_reg > smax_reg)
                                res_status_next = ST_RANGE;
                            else if ($signed(save_span) < $signed({1'b0, span_min_reg}))
                                res_status_next = ST_SPAN;
                            else
                            begin
                                ai_next        = pi_reg;
                                af_next        = pf_reg;
                                cal_next       = 1'b0;
                                res_width_next = pi_reg;
                                res_drive_next = 1'b1;
                            end
                        end
                        FN_CANCEL:
                        begin
                            if (!cal_reg)
                                res_status_next = ST_IGNORED;
                            else
                            begin
                                cal_next       = 1'b0;
                                res_width_next = ai_reg;
                                res_drive_next = 1'b1;
                            end
                        end
                        FN_QUERY_PCT:
                        begin
                            // degenerate window answers 0 without dividing
                            if (win_span != '0)
                            begin
                                mul_a_next = q_mag[DATA_W-1:0];
                                mul_b_next = {7'd0, PCT_QUERY_MAX};
                                den_next   = win_mag[DATA_W-1:0];
                                neg_next   = q_diff[DATA_W] ^ win_span[DATA_W];
                                query_next = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_IGNORED;
                        end
                    endcase
                    res_cal_next = cal_next;
                end
            end
            S_MUL:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (query_reg)
                    begin
                        if (neg_reg)
                            res_pct_next = '0;
                        else if (div_rsp.quotient > {{(DIVIDEND_W-7){1'b0}}, PCT_QUERY_MAX})
                            res_pct_next = PCT_QUERY_MAX;
                        else
                            res_pct_next = div_rsp.quotient[6:0];
                    end
                    else
                    begin
                        res_width_next = neg_reg ? (ai_reg - div_rsp.quotient[DATA_W-1:0])
                                                 : (ai_reg + div_rsp.quotient[DATA_W-1:0]);
                        res_drive_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            smin_reg      <= SERVO_MIN_RST;
            smax_reg      <= SERVO_MAX_RST;
            span_min_reg  <= MIN_SPAN_RST;
            ai_reg        <= DEFAULT_IDLE_US;
            af_reg        <= DEFAULT_FULL_US;
            pi_reg        <= DEFAULT_IDLE_US;
            pf_reg        <= DEFAULT_FULL_US;
            cal_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ai_reg        <= ai_next;
            af_reg        <= af_next;
            pi_reg        <= pi_next;
            pf_reg        <= pf_next;
            cal_reg       <= cal_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SERVO_MIN: smin_reg <= cfg_data;
                    REG_SERVO_MAX: smax_reg <= cfg_data;
                    REG_MIN_SPAN:  span_min_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        den_reg        <= den_next;
        neg_reg        <= neg_next;
        query_reg      <= query_next;
        res_width_reg  <= res_width_next;
        res_drive_reg  <= res_drive_next;
        res_status_reg <= res_status_next;
        res_pct_reg    <= res_pct_next;
        res_cal_reg    <= res_cal_next;
        if (rsp_load)
        begin
            rsp_width_reg  <= res_width_reg;
            rsp_drive_reg  <= res_drive_reg;
            rsp_status_reg <= res_status_reg;
            rsp_pct_reg    <= res_pct_reg;
            rsp_cal_reg    <= res_cal_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.servo_width    = rsp_width_reg;
    assign rsp.servo_drive    = rsp_drive_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.percent_out    = rsp_pct_reg;
    assign rsp.in_calibration = rsp_cal_reg;

    // mode flag only moves on a command transfer
    a_cal_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cal_reg) |-> $past(accept))
        else $error("calibration flag changed without a command transfer");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_drive_reg) |-> (rsp_width_reg == '0))
        else $error("undriven response carries a width");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_pct_reg <= PCT_QUERY_MAX))
        else $error("query answer above full scale");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_valid_reg) |-> rsp.ready)
        else $error("response register overwritten before transfer");

endmodule

// ===== sim/stc_response_checker.sv =====
// Checker for the servo throttle calibrator: watches the command, response and
// register-write ports, predicts every response and compares it field by field.
// Depends on stc_pkg and the channel interfaces in stc_if.sv.
module stc_response_checker
    import stc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    stc_cmd_if                cmd,
    stc_rsp_if                rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output int                resp_total,
    output int                fail_count
);

    localparam longint FULL_SCALE = 10000;

    typedef struct packed {
        logic [15:0] servo_width;
        logic        servo_drive;
        logic [2:0]  status;
        logic [6:0]  percent_out;
        logic        in_calibration;
    } servo_resp_t;

    // Shadow of the registers and the endpoint state
    logic [15:0] lim_lo, lim_hi, span_floor;
    logic [15:0] idle_us, full_us, new_idle, new_full;
    logic        cal_mode;

    servo_resp_t owed_q[$];
    int          mismatches;

    function automatic logic [15:0] fit_range(input logic [15:0] w);
        logic [15:0] v;
        v = (w < lim_lo) ? lim_lo : w;
        return (v > lim_hi) ? lim_hi : v;
    endfunction

    function automatic logic [15:0] demand_width(input logic signed [15:0] h);
        longint d, part;
        d = h;
        if (d < 0)
            d = 0;
        if (d > FULL_SCALE)
            d = FULL_SCALE;
        part = (longint'(full_us) - longint'(idle_us)) * d / FULL_SCALE;
        return 16'(longint'(idle_us) + part);
    endfunction

    function automatic logic [6:0] window_percent(input logic [15:0] w);
        int num, den, p;
        if (full_us == idle_us)
            return 7'd0;
        num = (int'(w) - int'(idle_us)) * 100;
        den = int'(full_us) - int'(idle_us);
        p = num / den;
        if (p < 0)
            p = 0;
        if (p > 100)
            p = 100;
        return 7'(p);
    endfunction

    // Applies one command to the shadow state and gives the response it owes
    function automatic servo_resp_t run_command(input logic [3:0] fn,
                                                input logic [15:0] w,
                                                input logic signed [15:0] h,
                                                input logic eng);
        servo_resp_t r;
        r = '0;
        case (fn)
            FN_SET_PCT, FN_SET_WIDTH, FN_GO_IDLE:
                if (cal_mode)
                    r.status = ST_IGNORED;
                else
                begin
                    r.servo_drive = 1'b1;
                    if (fn == FN_SET_PCT)
                        r.servo_width = demand_width(h);
                    else if (fn == FN_SET_WIDTH)
                        r.servo_width = fit_range(w);
                    else
                        r.servo_width = idle_us;
                end
            FN_BEGIN_CAL:
                if (eng)
                    r.status = ST_ENGINE;
                else
                begin
                    new_idle = idle_us;
                    new_full = full_us;
                    cal_mode = 1'b1;
                end
            FN_JOG_IDLE, FN_JOG_FULL:
                if (!cal_mode)
                    r.status = ST_IGNORED;
                else
                begin
                    r.servo_drive = 1'b1;
                    r.servo_width = fit_range(w);
                    if (fn == FN_JOG_IDLE)
                        new_idle = r.servo_width;
                    else
                        new_full = r.servo_width;
                end
            FN_SAVE:
                if (!cal_mode)
                    r.status = ST_IGNORED;
                else if (new_idle < lim_lo || new_full > lim_hi)
                    r.status = ST_RANGE;
                else if ((int'(new_full) - int'(new_idle)) < int'(span_floor))
                    r.status = ST_SPAN;
                else
                begin
                    idle_us = new_idle;
                    full_us = new_full;
                    cal_mode = 1'b0;
                    r.servo_drive = 1'b1;
                    r.servo_width = idle_us;
                end
            FN_CANCEL:
                if (!cal_mode)
                    r.status = ST_IGNORED;
                else
                begin
                    cal_mode = 1'b0;
                    r.servo_drive = 1'b1;
                    r.servo_width = idle_us;
                end
            FN_QUERY_PCT:
                r.percent_out = window_percent(w);
            default:
                r.status = ST_IGNORED;
        endcase
        r.in_calibration = cal_mode;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        servo_resp_t want;
        if (!rst_n)
        begin
            lim_lo = SERVO_MIN_RST;
            lim_hi = SERVO_MAX_RST;
            span_floor = MIN_SPAN_RST;
            idle_us = DEFAULT_IDLE_US;
            full_us = DEFAULT_FULL_US;
            new_idle = DEFAULT_IDLE_US;
            new_full = DEFAULT_FULL_US;
            cal_mode = 1'b0;
            owed_q.delete();
            mismatches = 0;
            resp_total <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: unexpected response, actual w %0d drv %0b st %0d pct %0d cal %0b",
                             $time, rsp.servo_width, rsp.servo_drive, rsp.status,
                             rsp.percent_out, rsp.in_calibration);
                    mismatches++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("servo_width", want.servo_width, rsp.servo_width);
                    check_field("servo_drive", want.servo_drive, rsp.servo_drive);
                    check_field("status", want.status, rsp.status);
                    check_field("percent_out", want.percent_out, rsp.percent_out);
                    check_field("in_calibration", want.in_calibration, rsp.in_calibration);
                end
                resp_total <= resp_total + 1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SERVO_MIN: lim_lo = cfg_data;
                    REG_SERVO_MAX: lim_hi = cfg_data;
                    REG_MIN_SPAN:  span_floor = cfg_data;
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                owed_q.push_back(run_command(cmd.func, cmd.width_us, cmd.pct_hundredths,
                                             cmd.engine_running));
            // responses still owed count against the run too
            fail_count <= mismatches + owed_q.size();
        end
    end

endmodule

// ===== sim/servo_throttle_calibrator_unit_tb.sv =====
// Testbench top for the servo throttle calibrator: clock, reset, command
// stimulus, response back-pressure, register writes and the verdict.
// Depends on stc_pkg, stc_if.sv, the RTL and stc_response_checker.
module servo_throttle_calibrator_unit_tb;
    import stc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [3:0] FN_SPARE = 4'd15;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [DATA_W-1:0] cfg_data;

    int resp_total, fail_count;
    int cmds_sent;
    int cmd_gap_pct, rsp_gap_pct;
    bit squeeze_req;
    logic [15:0] range_lo, range_hi;

    stc_cmd_if cmd_ch();
    stc_rsp_if rsp_ch();

    servo_throttle_calibrator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stc_response_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .resp_total (resp_total),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Response side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
                rsp_ch.ready <= 1'b1;
            end
            else if ($urandom_range(99) < rsp_gap_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic send_cmd(input logic [3:0] fn, input logic [15:0] w,
                            input logic [15:0] h, input logic eng);
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= fn;
        cmd_ch.width_us <= w;
        cmd_ch.pct_hundredths <= h;
        cmd_ch.engine_running <= eng;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        cmds_sent++;
        if ($urandom_range(99) < cmd_gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every transfer has had its response
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (resp_total != cmds_sent);
    endtask

    task automatic configure(input logic [15:0] lo, hi, span);
        range_lo = lo;
        range_hi = hi;
        cfg_we <= 1'b1;
        cfg_index <= REG_SERVO_MIN;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_SERVO_MAX;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= REG_MIN_SPAN;
        cfg_data <= span;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_width();
        int lo_i, hi_i;
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        lo_i = int'(range_lo) - 40;
        hi_i = int'(range_hi) + 40;
        if (lo_i < 0)
            lo_i = 0;
        if (hi_i > 65535)
            hi_i = 65535;
        return 16'($urandom_range(hi_i, lo_i));
    endfunction

    // Idle jogs mostly take the lower half of the servo range, full jogs the upper
    function automatic logic [15:0] jog_width(input bit upper);
        int mid_i;
        if (range_lo > range_hi || $urandom_range(4) == 0)
            return pick_width();
        mid_i = (int'(range_lo) + int'(range_hi)) / 2;
        if (upper)
            return 16'($urandom_range(int'(range_hi), mid_i));
        return 16'($urandom_range(mid_i, int'(range_lo)));
    endfunction

    function automatic logic [15:0] pick_demand();
        case ($urandom_range(9))
            0, 1: return 16'($urandom);
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(10003, 9997));
            default: return 16'($urandom_range(10000));
        endcase
    endfunction

    task automatic random_solo();
        logic [3:0] fn;
        if ($urandom_range(9) == 0)
            fn = 4'($urandom_range(FN_SPARE, FN_QUERY_PCT + 1));
        else
            fn = 4'($urandom_range(FN_QUERY_PCT, FN_SET_PCT));
        send_cmd(fn, pick_width(), pick_demand(), $urandom_range(3) == 0);
    endtask

    task automatic cal_sequence();
        if ($urandom_range(9) == 0)
        begin
            send_cmd(FN_BEGIN_CAL, pick_width(), pick_demand(), 1'b1);
            return;
        end
        send_cmd(FN_BEGIN_CAL, pick_width(), pick_demand(), 1'b0);
        repeat ($urandom_range(4))
        begin
            case ($urandom_range(5))
                0, 1: send_cmd(FN_JOG_IDLE, jog_width(1'b0), pick_demand(), 1'b0);
                2, 3: send_cmd(FN_JOG_FULL, jog_width(1'b1), pick_demand(), 1'b0);
                4: send_cmd(FN_QUERY_PCT, pick_width(), pick_demand(), 1'b0);
                default: send_cmd(4'($urandom_range(FN_GO_IDLE, FN_SET_PCT)), pick_width(),
                                  pick_demand(), 1'b0);
            endcase
        end
        case ($urandom_range(9))
            0, 1: send_cmd(FN_CANCEL, pick_width(), pick_demand(), 1'b0);
            2: ; // left in calibration
            default:
            begin
                send_cmd(FN_SAVE, pick_width(), pick_demand(), 1'b0);
                if ($urandom_range(1) == 1)
                    send_cmd(FN_CANCEL, pick_width(), pick_demand(), 1'b0);
            end
        endcase
    endtask

    task automatic random_phase(input int n);
        int goal;
        goal = cmds_sent + n;
        while (cmds_sent < goal)
        begin
            if ($urandom_range(9) < 6)
                cal_sequence();
            else
                random_solo();
        end
    endtask

    initial
    begin
        logic [15:0] rnd_lo;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SERVO_MIN;
        cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= FN_SET_PCT;
        cmd_ch.width_us <= '0;
        cmd_ch.pct_hundredths <= '0;
        cmd_ch.engine_running <= 1'b0;
        cmds_sent = 0;
        squeeze_req = 1'b0;
        range_lo = SERVO_MIN_RST;
        range_hi = SERVO_MAX_RST;
        cmd_gap_pct = 20;
        rsp_gap_pct = 20;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset window 1000..2000, servo range 500..2500
        send_cmd(FN_QUERY_PCT, 16'd1500, 16'd0, 1'b0);
        send_cmd(FN_QUERY_PCT, 16'hFFFF, 16'd0, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'h8000, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'h7FFF, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'd9999, 1'b0);
        send_cmd(FN_SET_WIDTH, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_SET_WIDTH, 16'hFFFF, 16'd0, 1'b0);
        send_cmd(FN_GO_IDLE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_JOG_IDLE, 16'd1200, 16'd0, 1'b0);
        send_cmd(FN_SAVE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_CANCEL, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_SPARE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_BEGIN_CAL, 16'd0, 16'd0, 1'b1);
        send_cmd(FN_BEGIN_CAL, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'd5000, 1'b0);
        send_cmd(FN_JOG_IDLE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_JOG_FULL, 16'hFFFF, 16'd0, 1'b0);
        send_cmd(FN_BEGIN_CAL, 16'd0, 16'd0, 1'b0);   // reload from active
        send_cmd(FN_JOG_IDLE, 16'd1500, 16'd0, 1'b0);
        send_cmd(FN_JOG_FULL, 16'd1550, 16'd0, 1'b0);
        send_cmd(FN_SAVE, 16'd0, 16'd0, 1'b0);         // span too small
        send_cmd(FN_QUERY_PCT, 16'd1750, 16'd0, 1'b0);
        send_cmd(FN_JOG_FULL, 16'd2400, 16'd0, 1'b0);
        send_cmd(FN_SAVE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_BEGIN_CAL, 16'd0, 16'd0, 1'b0);   // stays open into the next phase
        drain();

        // pending 1500..2400 now lies outside the narrowed servo range
        configure(16'd1600, 16'd2000, 16'd100);
        send_cmd(FN_SAVE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_CANCEL, 16'd0, 16'd0, 1'b0);
        squeeze_req = 1'b1;
        random_phase(90);
        drain();

        // widest range, zero span: full-scale window, then a degenerate one
        configure(16'd0, 16'hFFFF, 16'd0);
        cmd_gap_pct = 0;
        rsp_gap_pct = 30;
        send_cmd(FN_BEGIN_CAL, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_JOG_IDLE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_JOG_FULL, 16'hFFFF, 16'd0, 1'b0);
        send_cmd(FN_SAVE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'd10000, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'd3333, 1'b0);
        send_cmd(FN_QUERY_PCT, 16'hFFFF, 16'd0, 1'b0);
        send_cmd(FN_BEGIN_CAL, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_JOG_IDLE, 16'd3000, 16'd0, 1'b0);
        send_cmd(FN_JOG_FULL, 16'd3000, 16'd0, 1'b0);
        send_cmd(FN_SAVE, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_QUERY_PCT, 16'd3000, 16'd0, 1'b0);
        send_cmd(FN_SET_PCT, 16'd0, 16'd5000, 1'b0);
        random_phase(80);
        drain();

        // inverted range: the clamp always lands on the maximum
        configure(16'hFFFF, 16'd0, 16'hFFFF);
        cmd_gap_pct = 30;
        rsp_gap_pct = 0;
        random_phase(70);
        drain();

        rnd_lo = 16'($urandom_range(2000));
        configure(rnd_lo, rnd_lo + 16'($urandom_range(3000)), 16'($urandom_range(500)));
        cmd_gap_pct = 25;
        rsp_gap_pct = 25;
        random_phase(100);
        drain();

        configure(SERVO_MIN_RST, SERVO_MAX_RST, MIN_SPAN_RST);
        cmd_gap_pct = 0;
        rsp_gap_pct = 0;
        random_phase(100);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
